### hw/rtl/irt8_pkg.sv
// Shared constants, codes and types for the intensity range to 8-bit converter.
package irt8_pkg;

    // Field widths
    localparam int SAMPLE_W      = 32;
    localparam int U16_W         = 16;
    localparam int PIX_W         = 8;
    localparam int FRACTION_BITS = 16;
    localparam int FULL_SCALE    = (1 << PIX_W) - 1;

    // Divider sizing: numerator is diff * 255, divisor up to 32 bits
    localparam int DEN_W     = SAMPLE_W;
    localparam int NUM_W     = DEN_W + PIX_W;
    localparam int QUO_W     = PIX_W + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Item and format codes
    localparam logic MODE_SCAN    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;
    localparam logic FMT_UNSIGNED = 1'b0;
    localparam logic FMT_SIGNED   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // Divider start request
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    // Divider completion status
    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quot;
    } t_div_rsp;

endpackage

### hw/rtl/irt8_div.sv
// Radix-2 restoring divider with a saturated 8-bit quotient.
module irt8_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irt8_pkg::t_div_req i_req,
    output irt8_pkg::t_div_rsp o_rsp
);
    import irt8_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_dsh, n_dsh;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic             ge;

    // One compare/subtract per cycle against the shifted divisor
    assign ge = (r_rem >= r_dsh);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.num;
            n_dsh  = {i_req.den, PIX_W'(0)};
            n_quo  = '0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_quo = {r_quo[QUO_W-2:0], ge};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
    end

    // A quotient of 256 or more saturates to full scale
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo[QUO_W-1] ? PIX_W'(FULL_SCALE) : r_quo[PIX_W-1:0];

endmodule

### hw/rtl/intensity_range_to_8bit.sv
// Top level: two-pass min/max intensity normalization to 8-bit pixels.
// Scan item: passes through ST_EXEC and back to ready after its transfer, no result.
// Convert item with direct result (passthrough, equal range, below min): ST_EXEC, then ST_DONE.
// Convert item needing the range division: ST_EXEC, ST_MUL, ST_DIV, ST_DONE, waiting on the 9-step shared divider.
// One item in flight; the finished pixel sits in an output register while the next item enters.
// Synchronous active-low reset clears control state, the format register and min/max to zero.
module intensity_range_to_8bit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic                                 i_first_of_scan,
    input  logic signed [irt8_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [irt8_pkg::PIX_W-1:0]           o_pixel_out,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_data
);
    import irt8_pkg::*;

    t_state              r_state, n_state;
    logic                r_format;
    logic                r_mode;
    logic                r_first;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_max, n_max;
    logic [SAMPLE_W-1:0] r_min, n_min;
    logic [DEN_W-1:0]    r_diff, n_diff;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [PIX_W-1:0]    r_res, n_res;
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_pixel;
    logic                load_out;
    logic                in_acc;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic [U16_W-1:0]        u_val;
    logic [U16_W-1:0]        u_max;
    logic [U16_W-1:0]        u_min;
    logic                    s_range;
    logic signed [SAMPLE_W:0] s_diff;
    logic signed [SAMPLE_W:0] s_den;
    logic                    s_neg;
    logic [SAMPLE_W-1:0]     s_mag;
    logic [SAMPLE_W-1:0]     s_int;
    logic [PIX_W-1:0]        eq_pix;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Unsigned view of sample and range
    assign u_val = r_sample[U16_W-1:0];
    assign u_max = r_max[U16_W-1:0];
    assign u_min = r_min[U16_W-1:0];

    // Signed range and offset from min
    assign s_range = $signed(r_max) > $signed(r_min);
    assign s_diff  = $signed({r_sample[SAMPLE_W-1], r_sample})
                   - $signed({r_min[SAMPLE_W-1], r_min});
    assign s_den   = $signed({r_max[SAMPLE_W-1], r_max})
                   - $signed({r_min[SAMPLE_W-1], r_min});

    // Equal range: integer part truncated toward zero, low byte
    assign s_neg  = r_sample[SAMPLE_W-1];
    assign s_mag  = s_neg ? (~r_sample + SAMPLE_W'(1)) : r_sample;
    assign s_int  = s_mag >> FRACTION_BITS;
    assign eq_pix = s_neg ? (PIX_W'(0) - s_int[PIX_W-1:0]) : s_int[PIX_W-1:0];

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_max         = r_max;
        n_min         = r_min;
        n_diff        = r_diff;
        n_den         = r_den;
        n_res         = r_res;
        div_req.start = 1'b0;
        // Divider operands: diff * 255 as a shift and subtract
        div_req.num   = (NUM_W'(r_diff) << PIX_W) - NUM_W'(r_diff);
        div_req.den   = r_den;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_mode == MODE_SCAN) begin
                    // Range tracking
                    if (r_format == FMT_UNSIGNED) begin
                        if (r_first) begin
                            n_max = SAMPLE_W'(u_val);
                            n_min = SAMPLE_W'(u_val);
                        end else begin
                            if (u_val > u_max) n_max = SAMPLE_W'(u_val);
                            if (u_val < u_min) n_min = SAMPLE_W'(u_val);
                        end
                    end else begin
                        if (r_first) begin
                            n_max = r_sample;
                            n_min = r_sample;
                        end else begin
                            if ($signed(r_sample) > $signed(r_max)) n_max = r_sample;
                            if ($signed(r_sample) < $signed(r_min)) n_min = r_sample;
                        end
                    end
                    n_state = ST_IDLE;
                end else if (r_format == FMT_UNSIGNED) begin
                    if (u_max <= U16_W'(FULL_SCALE)) begin
                        n_res   = u_val[PIX_W-1:0];
                        n_state = ST_DONE;
                    end else begin
                        n_diff  = DEN_W'(u_val);
                        n_den   = DEN_W'(u_max);
                        n_state = ST_MUL;
                    end
                end else begin
                    if (!s_range) begin
                        n_res   = eq_pix;
                        n_state = ST_DONE;
                    end else if (s_diff[SAMPLE_W]) begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_diff  = s_diff[DEN_W-1:0];
                        n_den   = s_den[DEN_W-1:0];
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                div_req.start = 1'b1;
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quot;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, format register and range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_format <= FMT_UNSIGNED;
            r_max    <= '0;
            r_min    <= '0;
        end else begin
            r_state <= n_state;
            r_max   <= n_max;
            r_min   <= n_min;
            if (i_cfg_we) begin
                r_format <= i_cfg_data;
            end
        end
    end

    // Item capture and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= i_mode;
            r_first  <= i_first_of_scan;
            r_sample <= i_sample;
        end
        r_diff <= n_diff;
        r_den  <= n_den;
        r_res  <= n_res;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_pixel <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel;

    // Shared divider
    irt8_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // A scan item passes through ST_EXEC and returns to ready after its transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_SCAN) |-> ##2 (r_state == ST_IDLE))
        else $error("scan item did not complete in two cycles");

    // Divider completion only while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider done outside wait state");

    // A finished pixel with a free output register is presented next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished pixel not presented");

    // First scan item collapses the range to one value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_mode == MODE_SCAN && r_first) |=> (r_max == r_min))
        else $error("range not restarted on first scan item");

endmodule

### dv/testbench.sv
// Self-checking testbench for the two-pass intensity range to 8-bit converter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import irt8_pkg::*;

    localparam int ITEM_TARGET    = 540;
    localparam int SETTLE_CYCLES  = 20;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int QUIET_ITEMS    = 60;

    // One row of the directed stimulus table
    typedef struct {
        logic              fmt;
        logic              mode;
        logic              first;
        logic [SAMPLE_W-1:0] sample;
        bit                fixed;
        logic [PIX_W-1:0]  pix;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_mode = MODE_SCAN;
    logic                       i_first_of_scan = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [PIX_W-1:0]           o_pixel_out;
    logic                       i_cfg_we = 1'b0;
    logic                       i_cfg_data = FMT_UNSIGNED;

    // Side data that travels with the payload: a typed-in expected pixel
    bit                         drv_fixed = 1'b0;
    logic [PIX_W-1:0]           drv_pix = '0;

    // Predictor state
    logic                       fmt_m = FMT_UNSIGNED;
    logic [SAMPLE_W-1:0]        range_hi = '0;
    logic [SAMPLE_W-1:0]        range_lo = '0;
    logic [PIX_W-1:0]           pix_q [$];

    int unsigned                err_count = 0;
    int unsigned                n_sent = 0;
    int unsigned                idle_cycles = 0;
    bit                         quiet = 1'b0;
    bit                         long_hold_req = 1'b0;
    logic                       cur_fmt = FMT_UNSIGNED;

    t_row dir_rows [0:24] = '{
        // convert before any scan: reset range, plain passthrough
        '{FMT_UNSIGNED, MODE_CONVERT, 1'b0, 32'h0000_1234, 1'b1, 8'h34},
        // upper bits ignored in unsigned format
        '{FMT_UNSIGNED, MODE_CONVERT, 1'b0, 32'hFFFF_FFFF, 1'b1, 8'hFF},
        '{FMT_UNSIGNED, MODE_SCAN,    1'b1, 32'h0000_0064, 1'b0, 8'h00},
        '{FMT_UNSIGNED, MODE_SCAN,    1'b0, 32'h0000_00C8, 1'b0, 8'h00},
        '{FMT_UNSIGNED, MODE_CONVERT, 1'b0, 32'h0000_00AB, 1'b1, 8'hAB},
        '{FMT_UNSIGNED, MODE_SCAN,    1'b1, 32'hFFFF_FFFF, 1'b0, 8'h00},
        '{FMT_UNSIGNED, MODE_SCAN,    1'b0, 32'h0000_0000, 1'b0, 8'h00},
        '{FMT_UNSIGNED, MODE_CONVERT, 1'b0, 32'h0000_FFFF, 1'b1, 8'hFF},
        '{FMT_UNSIGNED, MODE_CONVERT, 1'b0, 32'h0000_0000, 1'b1, 8'h00},
        '{FMT_UNSIGNED, MODE_CONVERT, 1'b0, 32'h0000_8000, 1'b0, 8'h00},
        // scan continuing without a first item
        '{FMT_UNSIGNED, MODE_SCAN,    1'b0, 32'h7FFF_0100, 1'b0, 8'h00},
        // format switched between passes
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'h0001_0000, 1'b0, 8'h00},
        '{FMT_SIGNED,   MODE_SCAN,    1'b1, 32'h0005_0000, 1'b0, 8'h00},
        // equal range: truncated integer part, wrapping
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'hFFFE_8000, 1'b1, 8'hFF},
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'h0123_0000, 1'b1, 8'h23},
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'h8000_0000, 1'b1, 8'h00},
        '{FMT_SIGNED,   MODE_SCAN,    1'b0, 32'h8000_0000, 1'b0, 8'h00},
        '{FMT_SIGNED,   MODE_SCAN,    1'b0, 32'h7FFF_FFFF, 1'b0, 8'h00},
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'h7FFF_FFFF, 1'b1, 8'hFF},
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'h0000_0000, 1'b0, 8'h00},
        '{FMT_SIGNED,   MODE_SCAN,    1'b1, 32'h0001_0000, 1'b0, 8'h00},
        '{FMT_SIGNED,   MODE_SCAN,    1'b0, 32'h0002_0000, 1'b0, 8'h00},
        // below min saturates low, above max saturates high
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'h0000_0000, 1'b1, 8'h00},
        '{FMT_SIGNED,   MODE_CONVERT, 1'b0, 32'h0003_0000, 1'b1, 8'hFF},
        '{FMT_UNSIGNED, MODE_CONVERT, 1'b0, 32'h0000_1000, 1'b0, 8'h00}
    };

    intensity_range_to_8bit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_first_of_scan (i_first_of_scan),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_out     (o_pixel_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Range tracking for one scan item
    function automatic void track_range(input logic first, input logic [SAMPLE_W-1:0] raw);
        logic [U16_W-1:0]           v16;
        logic signed [SAMPLE_W-1:0] sv;
        logic signed [SAMPLE_W-1:0] shi;
        logic signed [SAMPLE_W-1:0] slo;
        v16 = raw[U16_W-1:0];
        sv  = raw;
        shi = range_hi;
        slo = range_lo;
        if (fmt_m == FMT_UNSIGNED) begin
            if (first) begin
                range_hi = {16'd0, v16};
                range_lo = {16'd0, v16};
            end else begin
                if (v16 > range_hi[U16_W-1:0]) range_hi = {16'd0, v16};
                if (v16 < range_lo[U16_W-1:0]) range_lo = {16'd0, v16};
            end
        end else begin
            if (first) begin
                range_hi = raw;
                range_lo = raw;
            end else begin
                if (sv > shi) range_hi = raw;
                if (sv < slo) range_lo = raw;
            end
        end
    endfunction

    // Byte for one convert item under the current range and format
    function automatic logic [PIX_W-1:0] scale_pixel(input logic [SAMPLE_W-1:0] raw);
        logic [U16_W-1:0]           v16;
        logic [U16_W-1:0]           mx16;
        logic signed [SAMPLE_W-1:0] sv;
        logic signed [SAMPLE_W-1:0] shi;
        logic signed [SAMPLE_W-1:0] slo;
        longint                     v;
        longint                     hi;
        longint                     lo;
        longint                     diff;
        longint                     quo;
        longint                     mag;
        longint                     ip;
        v16  = raw[U16_W-1:0];
        mx16 = range_hi[U16_W-1:0];
        sv   = raw;
        shi  = range_hi;
        slo  = range_lo;
        v    = sv;
        hi   = shi;
        lo   = slo;
        if (fmt_m == FMT_UNSIGNED) begin
            if (mx16 <= FULL_SCALE) return v16[PIX_W-1:0];
            quo = longint'(v16) * FULL_SCALE / longint'(mx16);
        end else if (hi > lo) begin
            diff = v - lo;
            if (diff < 0) return '0;
            quo = diff * FULL_SCALE / (hi - lo);
        end else begin
            // equal range: integer part truncated toward zero
            mag = (v < 0 ? -v : v) >> FRACTION_BITS;
            ip  = v < 0 ? -mag : mag;
            return ip[PIX_W-1:0];
        end
        return (quo > FULL_SCALE) ? PIX_W'(FULL_SCALE) : quo[PIX_W-1:0];
    endfunction

    // Random sample; spread narrows the value range
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic f, input int unsigned spread);
        logic [SAMPLE_W-1:0]        r;
        logic signed [SAMPLE_W-1:0] rs;
        r = $urandom();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_FFFF;
            3: return 32'h0000_0000;
            default: ;
        endcase
        if (f == FMT_UNSIGNED) begin
            if ($urandom_range(0, 9) == 0) return r;
            return {16'd0, r[U16_W-1:0] >> spread};
        end
        rs = r;
        rs = rs >>> spread;
        return rs;
    endfunction

    // Scoreboard: output transfers first, then the input transfer of the same edge
    always @(posedge i_clk) begin
        logic [PIX_W-1:0] want;
        if (!i_rst_n) begin
            fmt_m    <= FMT_UNSIGNED;
            range_hi <= '0;
            range_lo <= '0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pix_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected pixel, expected none, actual %02h",
                             $time, o_pixel_out);
                end else begin
                    want = pix_q.pop_front();
                    if (o_pixel_out !== want) begin
                        err_count++;
                        $display("%0t: pixel mismatch, expected %02h, actual %02h",
                                 $time, want, o_pixel_out);
                    end
                end
            end
            if (i_cfg_we) fmt_m = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                if (i_mode == MODE_CONVERT) begin
                    want = drv_fixed ? drv_pix : scale_pixel(i_sample);
                    pix_q.push_back(want);
                end else begin
                    track_range(i_first_of_scan, i_sample);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 20) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // One input transfer, with an optional idle burst ahead of it
    task automatic send_item(input logic m, input logic f, input logic [SAMPLE_W-1:0] s,
                             input bit fx, input logic [PIX_W-1:0] px);
        if (!quiet && $urandom_range(0, 99) < 25) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_mode          <= m;
        i_first_of_scan <= f;
        i_sample        <= s;
        drv_fixed       <= fx;
        drv_pix         <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    // Hold the input until every pending pixel has come out and the block settles
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_format(input logic f);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= f;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_fmt = f;
    endtask

    // Stimulus
    initial begin
        int unsigned phase;
        int unsigned spread;
        int unsigned n_scan;
        int unsigned n_conv;
        logic        fmt_next;
        logic        first;
        phase = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].fmt != cur_fmt) set_format(dir_rows[r].fmt);
            send_item(dir_rows[r].mode, dir_rows[r].first, dir_rows[r].sample,
                      dir_rows[r].fixed, dir_rows[r].pix);
        end

        // random images: a scan pass then a convert pass
        while (n_sent < ITEM_TARGET) begin
            phase++;
            if (n_sent + QUIET_ITEMS > ITEM_TARGET) quiet = 1'b1;
            fmt_next = 1'($urandom_range(0, 1));
            if (fmt_next != cur_fmt || $urandom_range(0, 4) == 0) set_format(fmt_next);
            if (phase == 10) drain_results();
            spread = (cur_fmt == FMT_UNSIGNED) ? $urandom_range(0, 15) : $urandom_range(0, 31);
            n_scan = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 8);
            n_conv = $urandom_range(1, 10);
            for (int k = 0; k < n_scan; k++) begin
                first = (k == 0);
                if ($urandom_range(0, 19) == 0) first = ~first;
                send_item(MODE_SCAN, first, pick_sample(cur_fmt, spread), 1'b0, '0);
            end
            // now and then the format flips between the passes
            if ($urandom_range(0, 9) == 0) set_format(~cur_fmt);
            if (phase == 6) begin
                long_hold_req = 1'b1;
                n_conv = 20;
            end
            for (int k = 0; k < n_conv; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom(), 1'b0, '0);
                end else begin
                    send_item(MODE_CONVERT, 1'($urandom_range(0, 1)),
                              pick_sample(cur_fmt, spread), 1'b0, '0);
                end
            end
        end

        // wind down
        drain_results();
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
